// ===== rtl/bfa_pkg.sv =====
// Shared types, codes and helper functions of the bitmap first-fit allocator.
// No dependencies; every other file of the block refers to this package.
package bfa_pkg;

  localparam int CMD_W    = 1;
  localparam int INDEX_W  = 12;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 10;
  localparam int WORD_W   = 64;
  localparam int WADDR_W  = 6;
  localparam int ADDR_BYTES = 512;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;
  localparam logic [7:0]       BYTE_FULL = 8'hff;
  localparam logic [CFG_W-1:0] BYTES_RESET = 10'd512;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } bfa_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_EXAM,
    S_DONE
  } bfa_state_t;

  typedef struct packed {
    logic               rd_en;
    logic [WADDR_W-1:0] rd_addr;
    logic               wr_en;
    logic [WADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0]  wr_data;
  } bfa_mem_req_t;

  // {found, byte number} of the lowest byte that is not full
  function automatic logic [3:0] first_open_byte(input logic [WORD_W-1:0] w);
    logic [3:0] r;
    r = 4'd0;
    for (int j = 7; j >= 0; j--) begin
      if (w[j*8 +: 8] != BYTE_FULL) begin
        r = {1'b1, 3'(j)};
      end
    end
    return r;
  endfunction

  function automatic logic [2:0] first_clear_bit(input logic [7:0] b);
    logic [2:0] r;
    r = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (!b[k]) begin
        r = 3'(k);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/bfa_in_if.sv =====
// Request channel of the allocator: command and bit number.
// Depends on bfa_pkg for the field widths.
interface bfa_in_if;
  logic                          valid;
  logic                          ready;
  logic [bfa_pkg::CMD_W-1:0]     cmd;
  logic [bfa_pkg::INDEX_W-1:0]   bit_index;

  modport source (output valid, output cmd, output bit_index, input ready);
  modport sink   (input valid, input cmd, input bit_index, output ready);
endinterface

// ===== rtl/bfa_out_if.sv =====
// Result channel of the allocator: status and allocated bit number.
// Depends on bfa_pkg for the field widths.
interface bfa_out_if;
  logic                          valid;
  logic                          ready;
  logic [bfa_pkg::STATUS_W-1:0]  status;
  logic [bfa_pkg::INDEX_W-1:0]   allocated_index;

  modport source (output valid, output status, output allocated_index, input ready);
  modport sink   (input valid, input status, input allocated_index, output ready);
endinterface

// ===== rtl/bfa_cfg_if.sv =====
// Configuration write channel of the allocator: bytes in use.
// Depends on bfa_pkg for the data width.
interface bfa_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bfa_pkg::CFG_W-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/bfa_map_ram.sv =====
// Usage map storage: 64-bit words, one read and one write port, registered read.
// Per-word valid flags make unwritten words read as zero. Depends on bfa_pkg.
module bfa_map_ram #(
  parameter int WORDS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bfa_pkg::bfa_mem_req_t       req,
  output logic [bfa_pkg::WORD_W-1:0]  rd_data
);

  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [bfa_pkg::WORD_W-1:0] mem [WORDS];
  logic [bfa_pkg::WORD_W-1:0] rd_raw_r;
  logic [WORDS-1:0]           wvalid_r;
  logic                       rd_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_raw_r <= mem[req.rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvalid_r   <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        wvalid_r[req.wr_addr[AW-1:0]] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_r <= wvalid_r[req.rd_addr[AW-1:0]];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_raw_r : '0;

endmodule

// ===== rtl/bitmap_first_fit_allocator.sv =====
// Bitmap first-fit allocator: one transaction at a time. A free goes from acceptance
// through one map read and one write back to the result. An allocate reads the map one
// 64-bit word at a time from word 0, a read and an examine state per word as the single
// map read port is registered, until a word with a clear bit in the bytes in use turns
// up or the last word in use has been examined. Out-of-range frees and allocates with
// zero bytes in use answer without touching the map. A finished result waits in an
// output register while the next request is taken. The map reads as all zero after
// reset with no clearing pass; bytes_in_use may be written whenever the block is idle.
module bitmap_first_fit_allocator #(
  parameter int MAP_BYTES = 512
) (
  input  logic         clk,
  input  logic         rst_n,
  bfa_in_if.sink       in_chan,
  bfa_out_if.source    out_chan,
  bfa_cfg_if.sink      cfg_chan
);

  localparam int USED_BYTES = (MAP_BYTES < bfa_pkg::ADDR_BYTES) ? MAP_BYTES
                                                                : bfa_pkg::ADDR_BYTES;
  localparam int WORDS = (USED_BYTES + 7) / 8;
  localparam logic [bfa_pkg::CFG_W-1:0] USED_N = bfa_pkg::CFG_W'(USED_BYTES);

  bfa_pkg::bfa_state_t           state_r, state_nxt;
  logic [bfa_pkg::CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [bfa_pkg::INDEX_W-1:0]   idx_r, idx_nxt;
  logic [bfa_pkg::WADDR_W-1:0]   scan_w_r, scan_w_nxt;
  bfa_pkg::bfa_status_t          res_status_r, res_status_nxt;
  logic [bfa_pkg::INDEX_W-1:0]   res_index_r, res_index_nxt;
  logic [bfa_pkg::CFG_W-1:0]     bytes_in_use_r;
  logic                          out_valid_r;
  logic [bfa_pkg::STATUS_W-1:0]  out_status_r;
  logic [bfa_pkg::INDEX_W-1:0]   out_index_r;

  bfa_pkg::bfa_mem_req_t         mem_req;
  logic [bfa_pkg::WORD_W-1:0]    rd_data;
  logic [bfa_pkg::WORD_W-1:0]    masked;
  logic [bfa_pkg::CFG_W-1:0]     live_n;
  logic [bfa_pkg::CFG_W-1:0]     live_m1;
  logic [bfa_pkg::WADDR_W-1:0]   last_w;
  logic [3:0]                    open_byte;
  logic [2:0]                    open_bit;
  logic                          in_ready;
  logic                          out_load;

  bfa_map_ram #(.WORDS(WORDS)) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign live_n  = (bytes_in_use_r > USED_N) ? USED_N : bytes_in_use_r;
  assign live_m1 = live_n - 10'd1;
  assign last_w  = live_m1[8:3];

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      if ({1'b0, scan_w_r, 3'(j)} < live_n) begin
        masked[j*8 +: 8] = rd_data[j*8 +: 8];
      end else begin
        masked[j*8 +: 8] = bfa_pkg::BYTE_FULL;
      end
    end
  end

  assign open_byte = bfa_pkg::first_open_byte(masked);
  assign open_bit  = bfa_pkg::first_clear_bit(masked[open_byte[2:0]*8 +: 8]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    idx_r        <= idx_nxt;
    scan_w_r     <= scan_w_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    scan_w_nxt     = scan_w_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    mem_req        = '0;
    in_ready       = 1'b0;
    out_load       = 1'b0;
    case (state_r)
      bfa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_chan.valid) begin
          cmd_nxt       = in_chan.cmd;
          idx_nxt       = in_chan.bit_index;
          scan_w_nxt    = '0;
          res_index_nxt = '0;
          if (in_chan.cmd == bfa_pkg::CMD_FREE) begin
            if ({1'b0, in_chan.bit_index[11:3]} >= live_n) begin
              res_status_nxt = bfa_pkg::ST_RANGE;
              state_nxt      = bfa_pkg::S_DONE;
            end else begin
              state_nxt = bfa_pkg::S_RD;
            end
          end else if (live_n == '0) begin
            res_status_nxt = bfa_pkg::ST_FULL;
            state_nxt      = bfa_pkg::S_DONE;
          end else begin
            state_nxt = bfa_pkg::S_RD;
          end
        end
      end
      bfa_pkg::S_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = (cmd_r == bfa_pkg::CMD_FREE) ? idx_r[11:6] : scan_w_r;
        state_nxt       = bfa_pkg::S_EXAM;
      end
      bfa_pkg::S_EXAM: begin
        if (cmd_r == bfa_pkg::CMD_FREE) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = idx_r[11:6];
          mem_req.wr_data = rd_data & ~(64'd1 << idx_r[5:0]);
          res_status_nxt  = bfa_pkg::ST_OK;
          state_nxt       = bfa_pkg::S_DONE;
        end else if (open_byte[3]) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = scan_w_r;
          mem_req.wr_data = rd_data | (64'd1 << {open_byte[2:0], open_bit});
          res_status_nxt  = bfa_pkg::ST_OK;
          res_index_nxt   = {scan_w_r, open_byte[2:0], open_bit};
          state_nxt       = bfa_pkg::S_DONE;
        end else if (scan_w_r == last_w) begin
          res_status_nxt = bfa_pkg::ST_FULL;
          state_nxt      = bfa_pkg::S_DONE;
        end else begin
          scan_w_nxt = scan_w_r + 6'd1;
          state_nxt  = bfa_pkg::S_RD;
        end
      end
      bfa_pkg::S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = bfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bfa_pkg::S_IDLE;
      end
    endcase
  end

  assign in_chan.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_index_r  <= res_index_r;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.status          = out_status_r;
  assign out_chan.allocated_index = out_index_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_in_use_r <= bfa_pkg::BYTES_RESET;
    end else if (cfg_chan.valid) begin
      bytes_in_use_r <= cfg_chan.data;
    end
  end

  assign cfg_chan.ready = 1'b1;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (state_r != bfa_pkg::S_IDLE))
    else $error("accepted transaction did not start work");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bfa_pkg::S_RD && cmd_r == bfa_pkg::CMD_ALLOC) |-> (scan_w_r <= last_w))
    else $error("allocate scan past last word in use");

  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status != bfa_pkg::ST_OK) |-> (out_chan.allocated_index == '0))
    else $error("failed transaction carries a nonzero index");

  a_write_then_done: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |=> (state_r == bfa_pkg::S_DONE))
    else $error("map write not followed by result");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == bfa_pkg::S_DONE))
    else $error("result loaded outside of completion");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for bitmap_first_fit_allocator: a queue-fed driver with bursty
// requests, a stalling result sink and a shadow bitmap that predicts every reply.
// Depends on bfa_pkg, the three channel interfaces and the allocator RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_BYTES_TB = 512;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int LONG_HOLD    = 400;
  localparam int PHASE_ITEMS  = 92;

  typedef struct packed {
    logic [bfa_pkg::CMD_W-1:0]   cmd;
    logic [bfa_pkg::INDEX_W-1:0] bit_index;
  } request_t;

  typedef struct packed {
    bfa_pkg::bfa_status_t        status;
    logic [bfa_pkg::INDEX_W-1:0] allocated_index;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n;

  bfa_in_if  in_bus ();
  bfa_out_if out_bus ();
  bfa_cfg_if cfg_bus ();

  bitmap_first_fit_allocator #(
    .MAP_BYTES(MAP_BYTES_TB)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  logic [7:0]                shadow_map [MAP_BYTES_TB];
  logic [bfa_pkg::CFG_W-1:0] shadow_bytes;

  request_t request_q[$];
  reply_t   reply_q[$];

  int  failures;
  int  accepted_count;
  int  grant_count;
  int  full_count;
  int  range_count;
  int  free_count;
  int  cfg_count;
  int  cycle_count;
  bit  taken_flag;
  int  burst_left;
  int  gap_left;
  int  hold_left;
  bit  hold_done;
  logic [15:0] stall_mask;
  int  stall_pos;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int live_bytes_of(input logic [bfa_pkg::CFG_W-1:0] value);
    int n;
    n = value;
    if (n > MAP_BYTES_TB) n = MAP_BYTES_TB;
    if (n > bfa_pkg::ADDR_BYTES) n = bfa_pkg::ADDR_BYTES;
    return n;
  endfunction

  task automatic predict_request(input request_t req);
    int n;
    int b;
    int k;
    bit found;
    logic [7:0] v;
    reply_t rep;
    n = live_bytes_of(shadow_bytes);
    rep.status = bfa_pkg::ST_FULL;
    rep.allocated_index = '0;
    if (req.cmd == bfa_pkg::CMD_ALLOC) begin
      found = 1'b0;
      for (b = 0; b < n && !found; b++) begin
        v = shadow_map[b];
        if (v != bfa_pkg::BYTE_FULL) begin
          k = 0;
          while (k < 8 && v[k]) k++;
          shadow_map[b][k] = 1'b1;
          rep.status = bfa_pkg::ST_OK;
          rep.allocated_index = bfa_pkg::INDEX_W'(b * 8 + k);
          found = 1'b1;
        end
      end
      if (found) grant_count++;
      else full_count++;
    end else begin
      b = req.bit_index >> 3;
      if (b >= n) begin
        rep.status = bfa_pkg::ST_RANGE;
        range_count++;
      end else begin
        shadow_map[b][req.bit_index[2:0]] = 1'b0;
        rep.status = bfa_pkg::ST_OK;
        free_count++;
      end
    end
    reply_q.push_back(rep);
  endtask

  always @(posedge clk) begin : request_monitor
    request_t req;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      req.cmd = in_bus.cmd;
      req.bit_index = in_bus.bit_index;
      predict_request(req);
      void'(request_q.pop_front());
      accepted_count++;
      taken_flag = 1'b1;
    end
  end

  always @(posedge clk) begin : cfg_monitor
    if (rst_n && cfg_bus.valid && cfg_bus.ready) begin
      shadow_bytes = cfg_bus.data;
      cfg_count++;
    end
  end

  always @(negedge clk) begin : request_driver
    bit offer;
    request_t req;
    offer = 1'b0;
    req = '0;
    if (!rst_n) begin
      offer = 1'b0;
    end else if (in_bus.valid && !taken_flag) begin
      offer = 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
    end else if (request_q.size() > 0) begin
      offer = 1'b1;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end
    if (offer) req = request_q[0];
    taken_flag = 1'b0;
    in_bus.valid     <= offer;
    in_bus.cmd       <= req.cmd;
    in_bus.bit_index <= req.bit_index;
  end

  always @(negedge clk) begin : reply_sink
    bit ready_next;
    if (!hold_done && accepted_count >= 300 && request_q.size() > 20) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (stall_pos == 0) begin
      case ($urandom_range(0, 2))
        0: stall_mask = '0;
        1: stall_mask = 16'($urandom & $urandom);
        default: stall_mask = 16'($urandom | $urandom);
      endcase
    end
    if (hold_left > 0) begin
      hold_left--;
      ready_next = 1'b0;
    end else begin
      ready_next = !stall_mask[stall_pos];
    end
    stall_pos = (stall_pos + 1) % 16;
    out_bus.ready <= ready_next;
  end

  always @(posedge clk) begin : reply_checker
    reply_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (reply_q.size() == 0) begin
        $error("unexpected result: status %0d allocated_index %0d",
               out_bus.status, out_bus.allocated_index);
        failures++;
      end else begin
        want = reply_q.pop_front();
        if (out_bus.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_bus.status);
          failures++;
        end
        if (out_bus.allocated_index !== want.allocated_index) begin
          $error("allocated_index mismatch: expected %0d, actual %0d",
                 want.allocated_index, out_bus.allocated_index);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, reply_q.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic push_request(input logic [bfa_pkg::CMD_W-1:0] cmd, input int bit_index);
    request_t r;
    r.cmd = cmd;
    r.bit_index = bfa_pkg::INDEX_W'(bit_index);
    request_q.push_back(r);
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || reply_q.size() != 0 || in_bus.valid) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_bytes_in_use(input logic [bfa_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [bfa_pkg::CFG_W-1:0] value, input int count);
    int n;
    int span;
    int pick;
    wait_idle();
    write_bytes_in_use(value);
    n = live_bytes_of(value);
    span = n * 8 + 7;
    if (span > 4095) span = 4095;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) push_request(bfa_pkg::CMD_ALLOC, $urandom_range(0, 4095));
      else if (pick < 85) push_request(bfa_pkg::CMD_FREE, $urandom_range(0, span));
      else push_request(bfa_pkg::CMD_FREE, $urandom_range(0, 4095));
    end
  endtask

  initial begin : stimulus
    logic [bfa_pkg::CFG_W-1:0] phase_values [12];
    in_bus.valid     = 1'b0;
    in_bus.cmd       = '0;
    in_bus.bit_index = '0;
    out_bus.ready    = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.data     = '0;
    foreach (shadow_map[i]) shadow_map[i] = '0;
    shadow_bytes = bfa_pkg::BYTES_RESET;
    burst_left = 1;
    phase_values = '{10'd2, 10'd512, 10'd8, 10'd1, 10'd3, 10'd1023,
                     10'd16, 10'd0, 10'd5, 10'd600, 10'd64, 10'd4};
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // top index, clear-bit free, first allocations at reset size
    push_request(bfa_pkg::CMD_FREE, 4095);
    push_request(bfa_pkg::CMD_ALLOC, 4095);
    push_request(bfa_pkg::CMD_ALLOC, 0);
    push_request(bfa_pkg::CMD_FREE, 0);
    push_request(bfa_pkg::CMD_ALLOC, 0);
    push_request(bfa_pkg::CMD_FREE, 1);

    // one byte: fill to full, free past the end, refill
    wait_idle();
    write_bytes_in_use(10'd1);
    repeat (9) push_request(bfa_pkg::CMD_ALLOC, 0);
    push_request(bfa_pkg::CMD_FREE, 8);
    push_request(bfa_pkg::CMD_FREE, 7);
    push_request(bfa_pkg::CMD_ALLOC, 0);
    push_request(bfa_pkg::CMD_FREE, 4095);

    // zero bytes in use
    wait_idle();
    write_bytes_in_use(10'd0);
    push_request(bfa_pkg::CMD_ALLOC, 0);
    push_request(bfa_pkg::CMD_FREE, 0);

    // size above the addressable limit
    wait_idle();
    write_bytes_in_use(10'd1023);
    push_request(bfa_pkg::CMD_ALLOC, 0);
    push_request(bfa_pkg::CMD_FREE, 4095);

    foreach (phase_values[p]) run_phase(phase_values[p], PHASE_ITEMS);
    run_phase(10'($urandom_range(1, 1023)), PHASE_ITEMS);

    wait_idle();
    repeat (20) @(negedge clk);
    $display("covered %0d requests over %0d size settings, long sink hold %0s",
             accepted_count, cfg_count, hold_done ? "applied" : "not reached");
    $display("grants %0d, full %0d, out of range %0d, frees %0d",
             grant_count, full_count, range_count, free_count);
    if (failures == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== bitmap_first_fit_allocator.f =====
rtl/bfa_pkg.sv
rtl/bfa_in_if.sv
rtl/bfa_out_if.sv
rtl/bfa_cfg_if.sv
rtl/bfa_map_ram.sv
rtl/bitmap_first_fit_allocator.sv
tb/sv/testbench.sv
